[sv/gradient_colormap_sqrt_blend_macros.svh]
// Assertion macros for the gradient color map.
`ifndef GRADIENT_COLORMAP_SQRT_BLEND_MACROS_SVH
`define GRADIENT_COLORMAP_SQRT_BLEND_MACROS_SVH
`ifndef SYNTHESIS
`define GCM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GCM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define GCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/gcm_pkg.sv]
package gcm_pkg;
	localparam int MaxPoints = 16;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);
	localparam int NumStages = 46;
	localparam logic [15:0] FullScale = 16'hFFFF;
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_MAP = 1'b1;

	typedef struct packed {
		logic [15:0] level;
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
	} point_t;
endpackage

[sv/gcm_in_if.sv]
interface gcm_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [3:0]  point_index;
	logic [15:0] point_level;
	logic [15:0] point_red;
	logic [15:0] point_green;
	logic [15:0] point_blue;
	logic [15:0] pixel_value;
	modport source (output valid, mode, point_index, point_level, point_red, point_green,
		point_blue, pixel_value, input ready);
	modport sink (input valid, mode, point_index, point_level, point_red, point_green,
		point_blue, pixel_value, output ready);
endinterface

[sv/gcm_out_if.sv]
interface gcm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

[sv/gcm_cfg_if.sv]
interface gcm_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[sv/gcm_chan.sv]
// One color channel: square blend then a restoring square root, one pipeline step
// per stage. Stages: squares, products, sum, divide by 65535, then eight sqrt stages.
module gcm_chan import gcm_pkg::*; (
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic [15:0] w,
	output logic [15:0] y
);
	// Squares (stage A), products (stage B), sum (stage C), divide by 65535 (stage D).
	logic [31:0] aa_s1, bb_s1;
	logic [15:0] w_s1;
	logic [47:0] pa_s2, pb_s2;
	logic [48:0] acc_s3;
	logic [31:0] q_s4;
	logic [48:0] t;
	logic [32:0] qe;
	logic [48:0] rem;

	always_ff @(posedge clk) begin
		if (adv) begin
			aa_s1 <= 32'(a) * 32'(a);
			bb_s1 <= 32'(b) * 32'(b);
			w_s1 <= w;
			pa_s2 <= 48'(FullScale - w_s1) * 48'(aa_s1);
			pb_s2 <= 48'(w_s1) * 48'(bb_s1);
			acc_s3 <= 49'(pa_s2) + 49'(pb_s2);
			q_s4 <= qe[31:0];
		end
	end

	// x/65535 for x < 2^48: q0 = (x + (x>>16) + 1) >> 16 is within one of the quotient,
	// so the remainder decides whether to step it down or up.
	always_comb begin
		t = acc_s3 + (acc_s3 >> 16) + 49'd1;
		qe = 33'(t >> 16);
		rem = acc_s3 - 49'(qe) * 49'(FullScale);
		if (rem[48]) qe = qe - 33'd1;
		else if (rem >= 49'(FullScale)) qe = qe + 33'd1;
	end

	// Restoring sqrt of 32-bit value: 16 steps, two steps per stage over 8 stages.
	localparam int Steps = 16;
	logic [31:0] xr [1:Steps];
	logic [15:0] rr [1:Steps];
	logic [17:0] rm [1:Steps];
	logic [31:0] xq [0:Steps];
	logic [15:0] rq [0:Steps];
	logic [17:0] mq [0:Steps];

	assign xq[0] = q_s4;
	assign rq[0] = '0;
	assign mq[0] = '0;

	genvar i;
	generate
		for (i = 0; i < Steps; i++) begin : g_sq
			logic [17:0] trial;
			logic [17:0] shifted;
			always_comb begin
				shifted = {mq[i][15:0], xq[i][31:30]};
				trial = shifted - {rq[i], 2'b01};
				if (!trial[17]) begin
					rm[i+1] = trial;
					rr[i+1] = {rq[i][14:0], 1'b1};
				end else begin
					rm[i+1] = shifted;
					rr[i+1] = {rq[i][14:0], 1'b0};
				end
				xr[i+1] = {xq[i][29:0], 2'b00};
			end
			if (i % 2 == 1) begin : g_reg
				always_ff @(posedge clk) begin
					if (adv) begin
						xq[i+1] <= xr[i+1];
						rq[i+1] <= rr[i+1];
						mq[i+1] <= rm[i+1];
					end
				end
			end else begin : g_wire
				assign xq[i+1] = xr[i+1];
				assign rq[i+1] = rr[i+1];
				assign mq[i+1] = rm[i+1];
			end
		end
	endgenerate
	assign y = rq[Steps];
endmodule

[sv/gradient_colormap_sqrt_blend.sv]
// One transaction per cycle unless a waiting result stalls the pipeline; the table search, a 32-stage
// restoring divider for the weight, and the squared blend with a 16-step square root form
// one stalling pipeline.
// A mode-0 transaction writes the table and produces no result.
// Reset (arst_n low, asynchronous) clears all valid bits and sets num_points to 2;
// the table itself is undefined until written.
`include "gradient_colormap_sqrt_blend_macros.svh"
module gradient_colormap_sqrt_blend import gcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gcm_in_if.sink   in_ch,
	gcm_out_if.source out_ch,
	gcm_cfg_if.sink  cfg
);
	// Table lives in flops: every entry but the last is compared against the pixel at once.
	point_t      tbl_q [MaxPoints];
	logic [4:0]  num_points_q;
	logic [CntW-1:0] n_eff;
	logic [NumStages-1:0] vld;
	logic        adv;
	logic        stall;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= 5'd2;
		end else if (cfg.valid) begin
			num_points_q <= cfg.data;
		end
	end

	always_comb begin
		if (num_points_q < 5'd2) n_eff = CntW'(2);
		else if (32'(num_points_q) > MaxPoints) n_eff = CntW'(MaxPoints);
		else n_eff = CntW'(num_points_q);
	end

	// The pipeline moves as a whole; it stops only when the last result waits.
	assign stall = vld[NumStages-1] && !out_ch.ready;
	assign in_ch.ready = !stall;
	wire in_fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk) begin
		if (in_fire && in_ch.mode == MODE_WRITE) begin
			tbl_q[in_ch.point_index] <= '{in_ch.point_level, in_ch.point_red,
				in_ch.point_green, in_ch.point_blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (!stall) begin
			vld <= {vld[NumStages-2:0], in_fire && in_ch.mode == MODE_MAP};
		end
	end
	assign adv = !stall;

	// Stage 1: segment search. Walk up from the first segment while the value lies above
	// the next upper level; the walk stops at the first segment that holds the value.
	logic [IdxW-1:0] seg;
	logic        seg_run;
	always_comb begin
		seg = '0;
		seg_run = 1'b1;
		for (int k = 1; k < MaxPoints - 1; k++) begin
			if (seg_run && k + 2 <= 32'(n_eff) && in_ch.pixel_value > tbl_q[k].level)
				seg = IdxW'(k);
			else
				seg_run = 1'b0;
		end
	end

	// A value below the first point takes the color of point 0 whatever the search found.
	logic        below_c;
	assign below_c = in_ch.pixel_value < tbl_q[0].level;

	point_t      lo_s1, hi_s1;
	logic [15:0] v_s1;
	logic        below_s1;
	always_ff @(posedge clk) begin
		if (!stall) begin
			lo_s1 <= below_c ? tbl_q[0] : tbl_q[seg];
			hi_s1 <= tbl_q[IdxW'(seg + 1'b1)];
			v_s1 <= in_ch.pixel_value;
			below_s1 <= below_c;
		end
	end

	// Stage 2: numerator and denominator; special cases force the weight.
	logic [31:0] num_s2;
	logic [15:0] den_s2;
	logic        flat_s2;
	point_t      lo_s2, hi_s2;
	always_ff @(posedge clk) begin
		if (!stall) begin
			num_s2 <= 32'(FullScale) * 32'(v_s1 - lo_s1.level);
			den_s2 <= hi_s1.level - lo_s1.level;
			flat_s2 <= below_s1 || hi_s1.level <= lo_s1.level;
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
		end
	end

	// Stages 3..34: restoring divider, one quotient bit per stage.
	localparam int DivBits = 32;
	logic [31:0] dn [0:DivBits];
	logic [32:0] dr [0:DivBits];
	logic [15:0] dd [0:DivBits];
	logic        df [0:DivBits];
	point_t      dl [0:DivBits];
	point_t      dh [0:DivBits];
	assign dn[0] = num_s2;
	assign dr[0] = '0;
	assign dd[0] = den_s2;
	assign df[0] = flat_s2;
	assign dl[0] = lo_s2;
	assign dh[0] = hi_s2;
	genvar gi;
	generate
		for (gi = 0; gi < DivBits; gi++) begin : g_div
			logic [32:0] sh, tr;
			always_comb begin
				sh = {dr[gi][31:0], dn[gi][31]};
				tr = sh - 33'(dd[gi]);
			end
			always_ff @(posedge clk) begin
				if (!stall) begin
					dr[gi+1] <= tr[32] ? sh : tr;
					dn[gi+1] <= {dn[gi][30:0], ~tr[32]};
					dd[gi+1] <= dd[gi];
					df[gi+1] <= df[gi];
					dl[gi+1] <= dl[gi];
					dh[gi+1] <= dh[gi];
				end
			end
		end
	endgenerate

	// Saturate weight; flat cases blend with weight zero, which returns the left color.
	// Stages 35..46 are the per-channel blend and square root.
	logic [15:0] w_c;
	point_t      a_c;
	always_comb begin
		a_c = dl[DivBits];
		if (df[DivBits]) w_c = '0;
		else if (dn[DivBits] > 32'(FullScale)) w_c = FullScale;
		else w_c = dn[DivBits][15:0];
	end

	gcm_chan u_red (.clk, .adv(adv), .a(a_c.r), .b(dh[DivBits].r), .w(w_c), .y(out_ch.red));
	gcm_chan u_grn (.clk, .adv(adv), .a(a_c.g), .b(dh[DivBits].g), .w(w_c), .y(out_ch.green));
	gcm_chan u_blu (.clk, .adv(adv), .a(a_c.b), .b(dh[DivBits].b), .w(w_c), .y(out_ch.blue));

	assign out_ch.valid = vld[NumStages-1];

	`GCM_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
	`GCM_ASSERT_NEXT(a_cfg, clk, arst_n, cfg.valid, num_points_q == $past(cfg.data), "cfg lost")
	`GCM_ASSERT_IMPL(a_rdy, clk, arst_n, in_ch.ready == !(out_ch.valid && !out_ch.ready), "ready")
endmodule
